FILE: sv/strb_pkg.sv
// Shared types and constants for the sensor timestamp reorder buffer.
package strb_pkg;

	// Sensor kinds below this value are known; the temperature kind is refused as well.
	localparam logic [2:0] KIND_COUNT       = 3'd5;
	localparam logic [2:0] TEMPERATURE_KIND = 3'd4;

	// A tick never releases more entries than this.
	localparam logic [5:0] MAX_RESULTS = 6'd32;

	// Reorder delay after reset, in microseconds.
	localparam logic [19:0] DELAY_RESET = 20'd5000;

	// Request types.
	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// Result status codes.
	localparam logic [2:0] STATUS_ACCEPTED  = 3'd0;
	localparam logic [2:0] STATUS_BAD_KIND  = 3'd1;
	localparam logic [2:0] STATUS_LATE      = 3'd2;
	localparam logic [2:0] STATUS_DUPLICATE = 3'd3;
	localparam logic [2:0] STATUS_OVERFLOW  = 3'd4;
	localparam logic [2:0] STATUS_RELEASED  = 3'd5;
	localparam logic [2:0] STATUS_NONE      = 3'd6;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_INS_CMP,
		S_INS_WR,
		S_REL_RD,
		S_REL_CHK,
		S_REL_END
	} strb_state_t;

	typedef struct packed {
		logic        req_type;
		logic [2:0]  kind;
		logic [31:0] sample_time;
		logic [31:0] recv_time;
		logic [31:0] sequence_req;
		logic [31:0] data_x;
		logic [31:0] data_y;
		logic [31:0] data_z;
		logic [31:0] now_us;
		logic [5:0]  max_events;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  out_kind;
		logic [31:0] out_sample_us;
		logic [31:0] out_x;
		logic [31:0] out_y;
		logic [31:0] out_z;
		logic        last;
		logic [31:0] late_total;
		logic [31:0] duplicate_total;
		logic [31:0] overflow_total;
	} rsp_t;

	// One stored observation.
	typedef struct packed {
		logic [31:0] sample_time;
		logic [2:0]  kind;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} entry_t;

endpackage

FILE: sv/strb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module strb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: sv/sensor_timestamp_reorder_buffer_unit.sv
// Top level of the sensor timestamp reorder buffer: checks, sorted store and release control.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_stall  strb_pkg::req_t (push or release tick)
//   rsp      out        rsp_valid / rsp_stall  strb_pkg::rsp_t (one or more per request)
//   cfg      in         cfg_wr_en              cfg_wr_data (reorder delay, 20 bits)
//
// A refused push goes from S_CHECK straight back to idle. An insert moves up by one slot
// each stored entry that the new one sorts before, stopping at an entry that stays in place
// or at the bottom of the store; the sorted insert walks the store one entry per cycle
// through the single read and write port of the RAM, then writes the new entry in S_INS_WR.
// A tick reads and checks entries through S_REL_RD and S_REL_CHK and ends in S_REL_END, also
// at an entry not yet old enough. A new request is taken only after the previous one.
// Reset clears all control state and the counters; the store needs no clearing pass since
// only entries below the fill count are ever read. A stalled result holds the engine in
// place until it is transferred, while the output register lets the next request start.
module sensor_timestamp_reorder_buffer_unit #(
	parameter int DEPTH = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  strb_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output strb_pkg::rsp_t  rsp,
	input  logic            cfg_wr_en,
	input  logic [19:0]     cfg_wr_data
);

	import strb_pkg::*;

	// Index width of the store and width of a count that can hold DEPTH itself.
	localparam int IW      = $clog2(DEPTH);
	localparam int CW      = $clog2(DEPTH + 1);
	localparam int ENTRY_W = $bits(entry_t);

	// The store is a ring: logical slot p lives at physical address head + p, modulo DEPTH.
	function automatic logic [IW-1:0] phys(input logic [IW-1:0] head, input logic [CW-1:0] off);
		logic [CW:0] s;
		s = (CW + 1)'(head) + (CW + 1)'(off);
		if (s >= (CW + 1)'(DEPTH)) begin
			s = s - (CW + 1)'(DEPTH);
		end
		return s[IW-1:0];
	endfunction

	strb_state_t state_q, state_d;

	req_t            req_q;
	logic [19:0]     delay_q;
	logic [CW-1:0]   fill_q, fill_d;
	logic [IW-1:0]   head_q, head_d;
	logic [CW-1:0]   pos_q, pos_d;
	logic [5:0]      n_q, n_d;
	logic [5:0]      lim_q, lim_d;
	logic            pend_q, pend_d;
	entry_t          pend_entry_q, pend_entry_d;
	logic [31:0]     seq_q [4];
	logic [31:0]     seq_d [4];
	logic [3:0]      seen_q, seen_d;
	logic [31:0]     late_q, late_d;
	logic [31:0]     dup_q, dup_d;
	logic [31:0]     ovf_q, ovf_d;
	logic            out_valid_q;
	rsp_t            out_q, out_d;
	logic            out_load;
	logic            out_free;
	logic            accept;

	// RAM port signals.
	logic                ram_we;
	logic [IW-1:0]       ram_waddr;
	entry_t              ram_wdata;
	logic                ram_re;
	logic [IW-1:0]       ram_raddr;
	logic [ENTRY_W-1:0]  ram_rdata;
	entry_t              rd_entry;

	// Decoded push checks on the held request.
	logic        bad_kind;
	logic        is_late;
	logic        is_dup;
	logic [1:0]  kidx;
	logic [31:0] recv_diff;
	logic [31:0] seq_diff;
	logic [31:0] time_diff;
	logic        must_move;
	logic [31:0] age;
	logic        ripe;
	entry_t      new_entry;

	strb_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en  (ram_re),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

	assign rd_entry = entry_t'(ram_rdata);

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !out_valid_q || !rsp_stall;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// Kind check, and lateness and duplicate checks that are wrap-aware through the sign of a difference.
	assign kidx      = req_q.kind[1:0];
	assign bad_kind  = (req_q.kind >= KIND_COUNT) || (req_q.kind == TEMPERATURE_KIND);
	assign recv_diff = req_q.recv_time - req_q.sample_time;
	assign is_late   = recv_diff[31];
	assign seq_diff  = req_q.sequence_req - seq_q[kidx];
	assign is_dup    = seen_q[kidx] && (seq_diff[31] || (req_q.sequence_req == seq_q[kidx]));

	// During the insert walk, the entry just read moves up when the new one sorts before it.
	assign time_diff = req_q.sample_time - rd_entry.sample_time;
	assign must_move = time_diff[31] ||
		((req_q.sample_time == rd_entry.sample_time) && (req_q.kind < rd_entry.kind));

	// An entry is ripe for release once its age is not negative and reaches the delay.
	assign age  = req_q.now_us - rd_entry.sample_time;
	assign ripe = !age[31] && (age >= {12'd0, delay_q});

	assign new_entry = '{
		sample_time: req_q.sample_time,
		kind:        req_q.kind,
		x:           req_q.data_x,
		y:           req_q.data_y,
		z:           req_q.data_z
	};

	always_comb begin
		state_d      = state_q;
		fill_d       = fill_q;
		head_d       = head_q;
		pos_d        = pos_q;
		n_d          = n_q;
		lim_d        = lim_q;
		pend_d       = pend_q;
		pend_entry_d = pend_entry_q;
		seq_d        = seq_q;
		seen_d       = seen_q;
		late_d       = late_q;
		dup_d        = dup_q;
		ovf_d        = ovf_q;
		ram_we       = 1'b0;
		ram_waddr    = phys(head_q, pos_q);
		ram_wdata    = rd_entry;
		ram_re       = 1'b0;
		ram_raddr    = head_q;
		out_load     = 1'b0;
		out_d        = '0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.req_type == REQ_TICK) begin
						n_d     = '0;
						pend_d  = 1'b0;
						lim_d   = (req.max_events > MAX_RESULTS) ? MAX_RESULTS : req.max_events;
						state_d = S_REL_RD;
					end else begin
						state_d = S_CHECK;
					end
				end
			end

			S_CHECK: begin
				out_d.last = 1'b1;
				if (bad_kind) begin
					out_d.status = STATUS_BAD_KIND;
					if (out_free) begin
						out_load = 1'b1;
						state_d  = S_IDLE;
					end
				end else if (is_late) begin
					out_d.status = STATUS_LATE;
					if (out_free) begin
						late_d   = late_q + 32'd1;
						out_load = 1'b1;
						state_d  = S_IDLE;
					end
				end else if (is_dup) begin
					out_d.status = STATUS_DUPLICATE;
					if (out_free) begin
						dup_d    = dup_q + 32'd1;
						out_load = 1'b1;
						state_d  = S_IDLE;
					end
				end else if (fill_q == CW'(DEPTH)) begin
					// A full buffer still advances the kind's sequence.
					out_d.status = STATUS_OVERFLOW;
					if (out_free) begin
						seq_d[kidx]  = req_q.sequence_req;
						seen_d[kidx] = 1'b1;
						ovf_d        = ovf_q + 32'd1;
						out_load     = 1'b1;
						state_d      = S_IDLE;
					end
				end else begin
					seq_d[kidx]  = req_q.sequence_req;
					seen_d[kidx] = 1'b1;
					pos_d        = fill_q;
					if (fill_q == '0) begin
						state_d = S_INS_WR;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = phys(head_q, fill_q - CW'(1));
						state_d   = S_INS_CMP;
					end
				end
			end

			S_INS_CMP: begin
				// The read data holds the entry at slot pos - 1.
				if (must_move) begin
					ram_we    = 1'b1;
					ram_waddr = phys(head_q, pos_q);
					ram_wdata = rd_entry;
					pos_d     = pos_q - CW'(1);
					if (pos_q > CW'(1)) begin
						ram_re    = 1'b1;
						ram_raddr = phys(head_q, pos_q - CW'(2));
					end else begin
						state_d = S_INS_WR;
					end
				end else begin
					state_d = S_INS_WR;
				end
			end

			S_INS_WR: begin
				out_d.status = STATUS_ACCEPTED;
				out_d.last   = 1'b1;
				if (out_free) begin
					ram_we    = 1'b1;
					ram_waddr = phys(head_q, pos_q);
					ram_wdata = new_entry;
					fill_d    = fill_q + CW'(1);
					out_load  = 1'b1;
					state_d   = S_IDLE;
				end
			end

			S_REL_RD: begin
				if ((fill_q == '0) || (n_q == lim_q)) begin
					state_d = S_REL_END;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = head_q;
					state_d   = S_REL_CHK;
				end
			end

			S_REL_CHK: begin
				// A released entry waits in the pending register until it is known
				// whether another follows, which decides its last flag.
				out_d.status        = STATUS_RELEASED;
				out_d.out_kind      = pend_entry_q.kind;
				out_d.out_sample_us = pend_entry_q.sample_time;
				out_d.out_x         = pend_entry_q.x;
				out_d.out_y         = pend_entry_q.y;
				out_d.out_z         = pend_entry_q.z;
				if (!ripe) begin
					state_d = S_REL_END;
				end else if (!pend_q || out_free) begin
					out_load     = pend_q;
					pend_d       = 1'b1;
					pend_entry_d = rd_entry;
					head_d       = (head_q == IW'(DEPTH - 1)) ? '0 : head_q + IW'(1);
					fill_d       = fill_q - CW'(1);
					n_d          = n_q + 6'd1;
					state_d      = S_REL_RD;
				end
			end

			S_REL_END: begin
				out_d.last = 1'b1;
				if (pend_q) begin
					out_d.status        = STATUS_RELEASED;
					out_d.out_kind      = pend_entry_q.kind;
					out_d.out_sample_us = pend_entry_q.sample_time;
					out_d.out_x         = pend_entry_q.x;
					out_d.out_y         = pend_entry_q.y;
					out_d.out_z         = pend_entry_q.z;
				end else begin
					out_d.status = STATUS_NONE;
				end
				if (out_free) begin
					out_load = 1'b1;
					pend_d   = 1'b0;
					state_d  = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase

		// Every result carries the counters as they stand after its request.
		out_d.late_total      = late_d;
		out_d.duplicate_total = dup_d;
		out_d.overflow_total  = ovf_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			delay_q     <= DELAY_RESET;
			fill_q      <= '0;
			head_q      <= '0;
			pos_q       <= '0;
			n_q         <= '0;
			lim_q       <= '0;
			pend_q      <= 1'b0;
			seen_q      <= '0;
			late_q      <= '0;
			dup_q       <= '0;
			ovf_q       <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < 4; k++) begin
				seq_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				delay_q <= cfg_wr_data;
			end
			fill_q <= fill_d;
			head_q <= head_d;
			pos_q  <= pos_d;
			n_q    <= n_d;
			lim_q  <= lim_d;
			pend_q <= pend_d;
			seen_q <= seen_d;
			late_q <= late_d;
			dup_q  <= dup_d;
			ovf_q  <= ovf_d;
			seq_q  <= seq_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		pend_entry_q <= pend_entry_d;
		if (out_load) begin
			out_q <= out_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(DEPTH))
		else $error("fill count exceeds store depth");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !pend_q)
		else $error("released entry left pending after a tick");

	a_release_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REL_RD || state_q == S_REL_CHK) |-> n_q <= lim_q)
		else $error("tick released more entries than its limit");

	a_not_last_is_release: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && !out_d.last) |-> out_d.status == STATUS_RELEASED)
		else $error("non-final result that is not a release");

	a_insert_grows_by_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_WR && out_free) |=> fill_q == $past(fill_q) + CW'(1))
		else $error("insert did not grow the fill count by one");
`endif

endmodule
